// File: rtl/ctlat_pkg.sv
// shared constants, types and saturation helper for the crystal-to-lab transform
package ctlat_pkg;

  // sizes of the coefficient store and the fixed-point format
  localparam int NUM_POSITIONS = 32;
  localparam int FRAC_BITS     = 16;
  localparam int WORD_W        = 32;
  localparam int ROWS          = 3;
  localparam int COLS          = 4;
  localparam int COEF_PER_SET  = ROWS * COLS;
  localparam int TABLE_SETS    = NUM_POSITIONS * 4;
  localparam int SET_W         = $clog2(TABLE_SETS);
  localparam int BANK_W        = $clog2(COEF_PER_SET);
  localparam int ID_W          = 8;
  localparam int XTAL_W        = 2;
  localparam int POS_W         = ID_W - XTAL_W;
  localparam int ROW_IDX_W     = 2;
  localparam int COL_IDX_W     = 2;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int ROW_W         = ACC_W - FRAC_BITS + 1;

  // register stages from input accept to result
  localparam int NUM_STAGES    = 6;

  // crystal id fields
  localparam logic [ID_W-1:0] ID_POS_MASK  = ID_W'(16'hfffc);
  localparam logic [ID_W-1:0] ID_XTAL_MASK = ID_W'(16'h0003);

  // input word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_NEG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_POS = 1'b1;

  // rounding constant, one half in the product format
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COLS-1:0][WORD_W-1:0] coef_row_t;
  typedef logic [COEF_PER_SET-1:0][WORD_W-1:0] coef_set_t;
  typedef logic [ROWS-1:0][WORD_W-1:0] point_t;

  // per-stage advance strobes handed to the row datapaths
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // saturated word with overflow mark
  typedef struct packed {
    logic  ovf;
    word_t value;
  } sat_t;

  // clamp a wide signed value to one word
  function automatic sat_t sat_word(input logic signed [ROW_W-1:0] v);
    sat_t r;
    if (~|v[ROW_W-1:WORD_W-1] || &v[ROW_W-1:WORD_W-1]) begin
      r.ovf   = 1'b0;
      r.value = v[WORD_W-1:0];
    end else begin
      r.ovf   = 1'b1;
      r.value = v[ROW_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/crystal_to_lab_affine_transform.sv
// top level: crystal-to-lab affine transform with loadable coefficient store
// a transform word shows on m_tvalid once it has passed the register stages below
// throughput: one word per cycle while the output is not stalled; six register stages (store read, multiply,
//   two adder stages, round and clamp, y offset) with per-stage valid bits
// load words with an in-range id and row write the store when accepted; no load word gives a result
// reset clears the stage valid bits and both offsets; store content is undefined until loaded
module crystal_to_lab_affine_transform (
  input  logic                               clk,
  input  logic                               rst,
  // xtal_code[7:0], row[9:8], column[11:10], coefficient[43:12],
  // point_x[75:44], point_y[107:76], point_z[139:108], zero[143:140]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [143:0]                       s_tdata,
  // kind[0]
  input  logic [0:0]                         s_tuser,
  // lab_x[31:0], lab_y[63:32], lab_z[95:64]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [95:0]                        m_tdata,
  // error_flag[0]
  output logic [0:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctlat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctlat_pkg::WORD_W-1:0]       cfg_data
);

  // input fields
  logic                               kind;
  logic [ctlat_pkg::ID_W-1:0]         xtal_code;
  logic [ctlat_pkg::ROW_IDX_W-1:0]    row;
  logic [ctlat_pkg::COL_IDX_W-1:0]    column;
  logic [ctlat_pkg::WORD_W-1:0]       coefficient;
  ctlat_pkg::point_t                  point_in;

  logic [ctlat_pkg::POS_W-1:0]        pos_field;
  logic [ctlat_pkg::POS_W-1:0]        pos_m1;
  logic [ctlat_pkg::XTAL_W-1:0]       xtal;
  logic [ctlat_pkg::ID_W-1:0]         set_full;
  logic [ctlat_pkg::SET_W-1:0]        set_addr;
  logic                               id_ok;
  logic                               accept;
  logic                               coef_wr;

  logic [ctlat_pkg::NUM_STAGES:1]     vld;
  logic [ctlat_pkg::NUM_STAGES+1:1]   en;
  ctlat_pkg::stage_en_t               row_en;
  logic [ctlat_pkg::NUM_STAGES-1:1]   ok_pipe;
  ctlat_pkg::point_t                  point1;
  ctlat_pkg::coef_set_t               coef1;
  ctlat_pkg::sat_t                    rx;
  ctlat_pkg::sat_t                    ry;
  ctlat_pkg::sat_t                    rz;
  ctlat_pkg::word_t                   offset_neg;
  ctlat_pkg::word_t                   offset_pos;
  ctlat_pkg::word_t                   offset_sel;
  logic signed [ctlat_pkg::ROW_W-1:0] y_diff;
  ctlat_pkg::sat_t                    y_adj;
  ctlat_pkg::word_t                   lab_x;
  ctlat_pkg::word_t                   lab_y;
  ctlat_pkg::word_t                   lab_z;
  logic                               error_flag;

  // unpack the input word
  assign kind        = s_tuser[0];
  assign xtal_code   = s_tdata[7:0];
  assign row         = s_tdata[9:8];
  assign column      = s_tdata[11:10];
  assign coefficient = s_tdata[43:12];
  assign point_in[0] = s_tdata[75:44];
  assign point_in[1] = s_tdata[107:76];
  assign point_in[2] = s_tdata[139:108];

  // decode position and crystal, check range
  assign pos_field = ctlat_pkg::POS_W'((xtal_code & ctlat_pkg::ID_POS_MASK) >> ctlat_pkg::XTAL_W);
  assign xtal      = ctlat_pkg::XTAL_W'(xtal_code & ctlat_pkg::ID_XTAL_MASK);
  assign id_ok     = (pos_field != '0) &&
                     ((ctlat_pkg::POS_W+1)'(pos_field) <=
                      (ctlat_pkg::POS_W+1)'(ctlat_pkg::NUM_POSITIONS));
  assign pos_m1    = pos_field - ctlat_pkg::POS_W'(1);
  assign set_full  = {pos_m1, xtal};
  assign set_addr  = set_full[ctlat_pkg::SET_W-1:0];

  // stage advance chain, bubbles collapse
  assign en[ctlat_pkg::NUM_STAGES+1] = m_tready;
  for (genvar k = 1; k <= ctlat_pkg::NUM_STAGES; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign s_tready = en[1];
  assign accept   = s_tvalid && s_tready;
  assign coef_wr  = accept && kind == ctlat_pkg::KIND_LOAD && id_ok &&
                    row < ctlat_pkg::ROW_IDX_W'(ctlat_pkg::ROWS);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= accept && kind == ctlat_pkg::KIND_XFORM;
      end
      for (int k = 2; k <= ctlat_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_neg <= '0;
      offset_pos <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctlat_pkg::CFG_OFFSET_NEG: offset_neg <= cfg_data;
        ctlat_pkg::CFG_OFFSET_POS: offset_pos <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: store read, point and range flag
  ctlat_coef_store u_store (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_bank ({row, column}),
    .wr_addr (set_addr),
    .wr_data (coefficient),
    .rd_en   (en[1]),
    .rd_addr (set_addr),
    .rd_data (coef1)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      point1     <= point_in;
      ok_pipe[1] <= id_ok;
    end
    for (int k = 2; k <= ctlat_pkg::NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        ok_pipe[k] <= ok_pipe[k-1];
      end
    end
  end

  // stages 2 to 5: one datapath per row
  assign row_en.s2 = en[2];
  assign row_en.s3 = en[3];
  assign row_en.s4 = en[4];
  assign row_en.s5 = en[5];

  ctlat_row_mac u_row_x (
    .clk    (clk),
    .en     (row_en),
    .coef   (coef1[3:0]),
    .pt     (point1),
    .result (rx)
  );

  ctlat_row_mac u_row_y (
    .clk    (clk),
    .en     (row_en),
    .coef   (coef1[7:4]),
    .pt     (point1),
    .result (ry)
  );

  ctlat_row_mac u_row_z (
    .clk    (clk),
    .en     (row_en),
    .coef   (coef1[11:8]),
    .pt     (point1),
    .result (rz)
  );

  // stage 6: hemisphere offset on y, range error, output register
  assign offset_sel = ry.value[ctlat_pkg::WORD_W-1] ? offset_neg : offset_pos;
  assign y_diff     = ctlat_pkg::ROW_W'(ry.value) - ctlat_pkg::ROW_W'(offset_sel);
  assign y_adj      = ctlat_pkg::sat_word(y_diff);

  always_ff @(posedge clk) begin
    if (en[ctlat_pkg::NUM_STAGES]) begin
      if (ok_pipe[ctlat_pkg::NUM_STAGES-1]) begin
        lab_x      <= rx.value;
        lab_y      <= y_adj.value;
        lab_z      <= rz.value;
        error_flag <= rx.ovf || ry.ovf || rz.ovf || y_adj.ovf;
      end else begin
        lab_x      <= '0;
        lab_y      <= '0;
        lab_z      <= '0;
        error_flag <= 1'b1;
      end
    end
  end

  assign m_tvalid   = vld[ctlat_pkg::NUM_STAGES];
  assign m_tdata    = {lab_z, lab_y, lab_x};
  assign m_tuser[0] = error_flag;

endmodule

// File: rtl/ctlat_coef_store.sv
// coefficient store: one bank per matrix element, all twelve read in parallel
module ctlat_coef_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ctlat_pkg::BANK_W-1:0]   wr_bank,
  input  logic [ctlat_pkg::SET_W-1:0]    wr_addr,
  input  logic [ctlat_pkg::WORD_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [ctlat_pkg::SET_W-1:0]    rd_addr,
  output ctlat_pkg::coef_set_t           rd_data
);

  // one memory per row/column element, registered read
  for (genvar b = 0; b < ctlat_pkg::COEF_PER_SET; b++) begin : g_bank
    logic [ctlat_pkg::WORD_W-1:0] mem [ctlat_pkg::TABLE_SETS];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == ctlat_pkg::BANK_W'(b)) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[b] <= mem[rd_addr];
      end
    end
  end

endmodule

// File: rtl/ctlat_row_mac.sv
// one matrix row: three products, rounded sum, translation and saturation
module ctlat_row_mac (
  input  logic                  clk,
  input  ctlat_pkg::stage_en_t  en,
  input  ctlat_pkg::coef_row_t  coef,
  input  ctlat_pkg::point_t     pt,
  output ctlat_pkg::sat_t       result
);

  logic signed [ctlat_pkg::PROD_W-1:0]                 prod [ctlat_pkg::ROWS];
  logic signed [ctlat_pkg::PROD_W-1:0]                 prod2_d;
  logic signed [ctlat_pkg::ACC_W-1:0]                  acc_a;
  logic signed [ctlat_pkg::ACC_W-1:0]                  acc;
  logic signed [ctlat_pkg::ACC_W-ctlat_pkg::FRAC_BITS-1:0] acc_hi;
  logic signed [ctlat_pkg::ROW_W-1:0]                  row_sum;
  ctlat_pkg::word_t                                    trans2;
  ctlat_pkg::word_t                                    trans3;
  ctlat_pkg::word_t                                    trans4;

  // stage 2: exact products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < ctlat_pkg::ROWS; c++) begin
        prod[c] <= ctlat_pkg::word_t'(coef[c]) * ctlat_pkg::word_t'(pt[c]);
      end
      trans2 <= ctlat_pkg::word_t'(coef[ctlat_pkg::COLS-1]);
    end
  end

  // stage 3: first two products plus rounding half
  always_ff @(posedge clk) begin
    if (en.s3) begin
      acc_a   <= ctlat_pkg::ACC_W'(prod[0]) + ctlat_pkg::ACC_W'(prod[1])
                 + ctlat_pkg::ROUND_HALF;
      prod2_d <= prod[2];
      trans3  <= trans2;
    end
  end

  // stage 4: third product
  always_ff @(posedge clk) begin
    if (en.s4) begin
      acc    <= acc_a + ctlat_pkg::ACC_W'(prod2_d);
      trans4 <= trans3;
    end
  end

  // stage 5: drop fraction bits, add translation, clamp
  assign acc_hi  = acc[ctlat_pkg::ACC_W-1:ctlat_pkg::FRAC_BITS];
  assign row_sum = ctlat_pkg::ROW_W'(acc_hi) + ctlat_pkg::ROW_W'(trans4);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      result <= ctlat_pkg::sat_word(row_sum);
    end
  end

endmodule

// File: rtl/ctlat_checker.sv
// port-level checks for the crystal-to-lab transform, bound to the top level
module ctlat_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  logic idle_drain;

  assign idle_drain = !(s_tvalid && s_tready) && m_tready;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an open output lets every stage advance
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is open");

  // with the output open and no new word accepted, the pipeline drains
  a_drain: assert property (@(posedge clk) disable iff (rst)
    idle_drain ##1 idle_drain ##1 idle_drain ##1 idle_drain ##1 idle_drain ##1 idle_drain
    |=> !m_tvalid)
    else $error("result appeared with no word in flight");

endmodule

bind crystal_to_lab_affine_transform ctlat_checker u_ctlat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
